@@ rtl/bn_pkg.sv @@
// ---------------------------------------------------------------------------
// bn_pkg: shared types and constants for the batch normalisation unit
// Input and result word layouts, widths and the front/back queue entry.
// ---------------------------------------------------------------------------
`default_nettype none
package bn_pkg;

  localparam int unsigned NumChannelsDefault = 256;
  localparam int unsigned DataW = 32;
  localparam int unsigned VarW  = 31;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [7:0]               channel;
    logic signed [DataW-1:0]  sample;
    logic signed [DataW-1:0]  param_gamma;
    logic signed [DataW-1:0]  param_beta;
    logic signed [DataW-1:0]  param_mean;
    logic [VarW-1:0]          param_var;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    saturated;
    logic                    last_out;
  } out_word_t;

  // sample job handed from front to back: parameters already looked up
  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] gamma;
    logic signed [DataW-1:0] beta;
    logic signed [DataW-1:0] mean;
    logic [VarW-1:0]         var_q;
    logic                    last;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/bn_front.sv @@
// ---------------------------------------------------------------------------
// bn_front: input decode and parameter tables
// Loads write the four tables; samples read them and emit a job.
// ---------------------------------------------------------------------------
`default_nettype none
module bn_front
  import bn_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_word_t in_word,
  input  wire logic     push,
  output logic          full,
  output job_t          job,
  output logic          job_valid,
  input  wire logic     job_full
);
  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // ceil(2^16 / depth): exact quotient for any 8-bit channel
  localparam int unsigned Recip = (32'd65536 + NUM_CHANNELS - 1) / NUM_CHANNELS;

  logic signed [DataW-1:0] gamma_mem [NUM_CHANNELS];
  logic signed [DataW-1:0] beta_mem  [NUM_CHANNELS];
  logic signed [DataW-1:0] mean_mem  [NUM_CHANNELS];
  logic [VarW-1:0]         var_mem   [NUM_CHANNELS];

  logic [AW-1:0] addr;
  logic          take;
  logic [24:0]   ch_scaled;
  logic [20:0]   ch_rem;

  // channel modulo table depth, quotient by reciprocal multiply
  assign ch_scaled = 25'(in_word.channel) * 25'(Recip);
  assign ch_rem    = 21'(in_word.channel) - 21'(ch_scaled[24:16]) * 21'(NUM_CHANNELS);
  assign addr      = AW'(ch_rem);

  // stall while a looked-up job waits on a full queue
  assign full = job_valid && job_full;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (take && in_word.req_type == REQ_LOAD) begin
      gamma_mem[addr] <= in_word.param_gamma;
      beta_mem[addr]  <= in_word.param_beta;
      mean_mem[addr]  <= in_word.param_mean;
      var_mem[addr]   <= in_word.param_var;
    end
    if (take && in_word.req_type == REQ_SAMPLE) begin
      job.gamma <= gamma_mem[addr];
      job.beta  <= beta_mem[addr];
      job.mean  <= mean_mem[addr];
      job.var_q <= var_mem[addr];
      job.sample <= in_word.sample;
      job.last   <= in_word.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!full) begin
      job_valid <= take && in_word.req_type == REQ_SAMPLE;
    end
  end
endmodule
`default_nettype wire

@@ rtl/bn_queue.sv @@
// ---------------------------------------------------------------------------
// bn_queue: small FIFO for jobs between front and back
// Two entries, registers, first word fall-through.
// ---------------------------------------------------------------------------
`default_nettype none
module bn_queue
  import bn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t wr_data,
  input  wire logic wr_en,
  output logic      full,
  output job_t      rd_data,
  output logic      rd_valid,
  input  wire logic rd_en
);
  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_wr;
  logic       do_rd;

  assign full     = cnt == 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= ~wp;
      end
      if (do_rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule
`default_nettype wire

@@ rtl/bn_back.sv @@
// ---------------------------------------------------------------------------
// bn_back: sequential arithmetic for one sample
// Bit-serial sqrt, restoring divide, split multiply, round and saturate.
// ---------------------------------------------------------------------------
`default_nettype none
module bn_back
  import bn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_valid,
  output logic      job_pop,
  output out_word_t out_word,
  output logic      empty,
  input  wire logic pop
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQRT = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_MULL = 7'b0001000,
    S_MULH = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  // sqrt of (var+1)<<16 <= 2^47: 24 result bits
  logic [47:0] sq_rem;
  logic [23:0] sq_root;
  logic [47:0] sq_val;
  logic [4:0]  cnt;
  // divide |x-m|<<16 (< 2^49) by s
  logic [48:0] dv_num;
  logic [24:0] dv_rem;
  logic [48:0] dv_quo;
  logic [5:0]  dcnt;
  logic        neg;
  logic [31:0] ga;
  logic [63:0] prod;
  logic        big;
  logic signed [DataW-1:0] beta;
  logic        last;

  logic [49:0] sq_try;
  logic [49:0] sq_cur;
  logic [25:0] dv_sh;
  logic [32:0] diff;
  logic [32:0] diff_mag;
  logic [63:0] mul_lo;
  logic [40:0] mul_hi;
  logic [47:0] q_mag;
  logic signed [49:0] y;

  assign diff     = 33'(signed'(job.sample)) - 33'(signed'(job.mean));
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;
  assign sq_cur   = {sq_rem, sq_val[47:46]};
  assign sq_try   = {sq_cur[49:0]} - {24'd0, sq_root, 2'b01};
  assign dv_sh    = {dv_rem, dv_num[48]};
  assign mul_lo   = 64'(ga) * 64'(dv_quo[31:0]);
  assign mul_hi   = 41'(ga) * 41'(dv_quo[40:32]);
  assign q_mag    = neg ? 48'((prod + 64'hFFFF) >> 16) : 48'(prod >> 16);
  assign y        = neg ? (50'sd0 - signed'(50'(q_mag))) + 50'(beta)
                        : signed'(50'(q_mag)) + 50'(beta);

  assign empty   = state != S_OUT;
  assign job_pop = state == S_IDLE && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            sq_val  <= {1'b0, job.var_q, 16'd0} + 48'h1_0000;
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= 5'd23;
            dv_num  <= {diff_mag[32:0], 16'd0};
            neg     <= diff[32] != job.gamma[31];
            ga      <= job.gamma[31] ? (~job.gamma + 32'd1) : job.gamma;
            beta    <= job.beta;
            last    <= job.last;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_val <= {sq_val[45:0], 2'b00};
          if (!sq_try[49]) begin
            sq_rem  <= sq_try[47:0];
            sq_root <= {sq_root[22:0], 1'b1};
          end else begin
            sq_rem  <= sq_cur[47:0];
            sq_root <= {sq_root[22:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            dv_rem <= '0;
            dcnt   <= 6'd48;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          dv_num <= {dv_num[47:0], 1'b0};
          if (dv_sh >= {2'b00, sq_root}) begin
            dv_rem <= 25'(dv_sh - {2'b00, sq_root});
            dv_quo <= {dv_quo[47:0], 1'b1};
          end else begin
            dv_rem <= dv_sh[24:0];
            dv_quo <= {dv_quo[47:0], 1'b0};
          end
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) begin
            state <= S_MULL;
          end
        end
        S_MULL: begin
          // gamma sign vs quotient sign; zero quotient counts as positive
          if (dv_quo == '0) begin
            neg <= 1'b0;
          end else begin
            neg <= neg;
          end
          prod  <= mul_lo;
          big   <= mul_hi >= 41'h2_0000;
          state <= S_MULH;
        end
        S_MULH: begin
          prod  <= prod + {mul_hi[31:0], 32'd0};
          state <= S_FIN;
        end
        S_FIN: begin
          out_word.last_out <= last;
          if (big || y > 50'sh7FFF_FFFF) begin
            out_word.saturated <= 1'b1;
            out_word.result <= (big && neg) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else if (y < -50'sh8000_0000) begin
            out_word.saturated <= 1'b1;
            out_word.result    <= 32'sh8000_0000;
          end else begin
            out_word.saturated <= 1'b0;
            out_word.result    <= y[31:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/batchnorm_inference_unit.sv @@
// ---------------------------------------------------------------------------
// batchnorm_inference_unit: streaming Q16.16 batch normalisation
// Front (decode, tables), job queue, back (sqrt, divide, multiply).
// ---------------------------------------------------------------------------
// A load word writes a channel's gamma, beta, mean and variance and gives no
// result; a sample word gives one result y = gamma*(x-mean)/sqrt(var+eps) +
// beta, saturated to 32 bits, with the last mark carried through. Load words
// are taken one per cycle while the front is not stalled by a full job queue.
// A sample occupies the back end through the bit-serial square root, the
// restoring divide, the split multiply and a round-and-clip step, then it
// waits to be popped. The front looks up the tables and queues up to three
// samples so that loads and lookups keep flowing while the back end works.
`default_nettype none
module batchnorm_inference_unit
  import bn_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_word_t  in_word,
  input  wire logic      push,
  output logic           full,
  output out_word_t      out_word,
  output logic           empty,
  input  wire logic      pop
);
  job_t f_job;
  logic f_valid;
  logic q_full;
  job_t q_job;
  logic q_valid;
  logic q_pop;

  bn_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk, .rst, .in_word, .push, .full,
    .job(f_job), .job_valid(f_valid), .job_full(q_full)
  );

  bn_queue u_queue (
    .clk, .rst, .wr_data(f_job), .wr_en(f_valid), .full(q_full),
    .rd_data(q_job), .rd_valid(q_valid), .rd_en(q_pop)
  );

  bn_back u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_pop(q_pop),
    .out_word, .empty, .pop
  );
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for batchnorm_inference_unit
// Loads channel parameters, streams samples with random bursts and stalls,
// and checks every normalised word against a Q16.16 predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import bn_pkg::*;

  localparam int unsigned NumCh     = 256;
  localparam int unsigned NumRandom = 1100;
  localparam int unsigned CycleCap  = 1000000;
  localparam int unsigned DrainWait = 200;   // idle wait once no words are due
  localparam int unsigned LongHold  = 400;   // receiver hold-off, cycles

  // -------------------------------------------------------------------------
  // Parameter tables and the queue of normalised words still due
  // -------------------------------------------------------------------------
  class bn_scoreboard;
    logic signed [DataW-1:0] gamma_tab[NumCh];
    logic signed [DataW-1:0] beta_tab[NumCh];
    logic signed [DataW-1:0] mean_tab[NumCh];
    logic [VarW-1:0]         var_tab[NumCh];
    out_word_t               due_q[$];
    int                      errors;

    // floor square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
        if (v >= root + bitpos) begin
          v -= root + bitpos;
          root = (root >> 1) + bitpos;
        end else begin
          root >>= 1;
        end
        bitpos >>= 2;
      end
      return root;
    endfunction

    function void note_word(in_word_t w);
      longint                  x, m, s, n;
      logic signed [127:0]     acc;
      logic signed [DataW-1:0] g;
      out_word_t               exp_w;
      if (w.req_type == REQ_LOAD) begin
        gamma_tab[w.channel] = w.param_gamma;
        beta_tab[w.channel]  = w.param_beta;
        mean_tab[w.channel]  = w.param_mean;
        var_tab[w.channel]   = w.param_var;
        return;
      end
      x = w.sample;
      m = mean_tab[w.channel];
      g = gamma_tab[w.channel];
      // epsilon is one LSB, so s never drops below 256
      s = root_floor((64'(var_tab[w.channel]) + 1) << 16);
      n = ((x - m) * 65536) / s;            // truncates toward zero
      acc = g;
      acc = acc * n;
      acc = (acc >>> 16) + beta_tab[w.channel];   // floor, then shift by beta
      exp_w.saturated = 1'b1;
      if (acc > 128'sh7fffffff) exp_w.result = 32'h7fffffff;
      else if (acc < -128'sh80000000) exp_w.result = 32'h80000000;
      else begin
        exp_w.result = acc[31:0];
        exp_w.saturated = 1'b0;
      end
      exp_w.last_out = w.last_in;
      due_q.push_back(exp_w);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (due_q.size() == 0) begin
        $error("unexpected word: result %h", got.result);
        errors++;
        return;
      end
      exp_w = due_q.pop_front();
      if (got.result !== exp_w.result) begin
        $error("result: expected %h, actual %h", exp_w.result, got.result);
        errors++;
      end
      if (got.saturated !== exp_w.saturated) begin
        $error("saturated: expected %b, actual %b", exp_w.saturated, got.saturated);
        errors++;
      end
      if (got.last_out !== exp_w.last_out) begin
        $error("last_out: expected %b, actual %b", exp_w.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  in_word_t  in_word;
  logic      push;
  logic      full;
  out_word_t out_word;
  logic      empty;
  logic      pop;

  bn_scoreboard sb;
  int           words_out;
  bit           loaded[NumCh];
  int           loaded_q[$];   // channels safe to sample

  batchnorm_inference_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .push    (push),
    .full    (full),
    .out_word(out_word),
    .empty   (empty),
    .pop     (pop)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: covers the slowest legal run many times over
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleCap) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall pattern per window, plus one long hold-off
  // -------------------------------------------------------------------------
  initial begin
    int  mode, win;
    bit  held;
    pop = 1'b0;
    words_out = 0;
    held = 0;
    mode = 0;
    win = 0;
    @(negedge rst);
    forever begin
      if (!held && words_out == 150) begin
        // let the job queue fill so that full is asserted
        held = 1;
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (win == 0) begin
        mode = $urandom_range(0, 3);
        win = 64;
      end
      win--;
      case (mode)
        0: pop <= 1'b1;                               // no stalls
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);        // mostly stalled
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_word(out_word);
        words_out++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  int burst_left;

  function automatic logic [DataW-1:0] pick_data();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff);             // small positive
      3: return -$signed(32'($urandom_range(0, 32'h3ffff)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VarW-1:0] pick_var();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'd2147483646;
      2: return 31'($urandom_range(0, 32'h3ffff));
      default: return 31'($urandom & 32'h7fffffff);
    endcase
  endfunction

  // one word onto the input, waiting out full; push stays high in a burst
  task automatic send_word(in_word_t w);
    in_word <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_word(w);
    if (w.req_type == REQ_LOAD && !loaded[w.channel]) begin
      loaded[w.channel] = 1;
      loaded_q.push_back(int'(w.channel));
    end
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_load(logic [7:0] ch, logic [31:0] g, logic [31:0] b,
                           logic [31:0] m, logic [VarW-1:0] v);
    in_word_t w;
    w.req_type = REQ_LOAD;
    w.channel = ch;
    w.param_gamma = g;
    w.param_beta = b;
    w.param_mean = m;
    w.param_var = v;
    w.sample = $urandom;                // ignored on a load
    w.last_in = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  task automatic send_sample(logic [7:0] ch, logic [31:0] x, logic lst);
    in_word_t w;
    w.req_type = REQ_SAMPLE;
    w.channel = ch;
    w.sample = x;
    w.last_in = lst;
    w.param_gamma = $urandom;           // ignored on a sample
    w.param_beta = $urandom;
    w.param_mean = $urandom;
    w.param_var = 31'($urandom);
    send_word(w);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    in_word = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit scale, extremes of every field, both saturation sides
    send_load(8'd0, 32'h00010000, 32'd0, 32'd0, 31'h0000ffff);
    send_sample(8'd0, 32'h00010000, 1'b1);
    send_sample(8'd0, 32'hffff0000, 1'b0);
    send_load(8'd255, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'd0);
    send_sample(8'd255, 32'h7fffffff, 1'b1);      // clips high
    send_sample(8'd255, 32'h80000000, 1'b0);
    send_load(8'd1, 32'h80000000, 32'h80000000, 32'h7fffffff, 31'd2147483646);
    send_sample(8'd1, 32'h80000000, 1'b0);
    send_sample(8'd1, 32'h7fffffff, 1'b1);
    send_load(8'd2, 32'h7fffffff, 32'h80000000, 32'd0, 31'd0);
    send_sample(8'd2, 32'h80000000, 1'b1);        // clips low
    send_sample(8'd2, 32'd0, 1'b0);
    send_load(8'd128, 32'd0, 32'h12345678, 32'hdeadbeef, 31'h55555555);
    send_sample(8'd128, 32'hffffffff, 1'b0);      // gamma zero gives beta
    send_load(8'd3, 32'hffff0000, 32'h00008000, 32'h00000001, 31'd1);
    send_sample(8'd3, 32'h00000001, 1'b1);        // x equals mean
    send_sample(8'd3, 32'h00000000, 1'b0);        // tiny positive product
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) wait_drained();     // pause until all are back
      if ($urandom_range(0, 99) < 30)
        send_load(8'($urandom_range(0, 255)), pick_data(), pick_data(), pick_data(),
                  pick_var());
      else
        send_sample(8'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]), pick_data(),
                    1'($urandom_range(0, 1)));
    end
    push <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/bn_pkg.sv
rtl/bn_front.sv
rtl/bn_queue.sv
rtl/bn_back.sv
rtl/batchnorm_inference_unit.sv
test/tb_top.sv
